/* rtl/core/wad_pkg.sv */
// shared widths and types for the dual axis window average block
`default_nettype none

package wad_pkg;

	// raw converter sample width and signed result width
	localparam int IN_W  = 10;
	localparam int OUT_W = 11;

	// stream bus widths, data buses padded to whole bytes
	localparam int S_TDATA_W = 24;
	localparam int M_TDATA_W = 48;
	localparam int M_TUSER_W = 1;

	// what one axis lane hands to the merging stage
	typedef struct packed {
		logic [IN_W-1:0] full;
		logic [IN_W-1:0] recent;
	} lane_mean_t;

endpackage

`default_nettype wire

/* rtl/core/dual_axis_window_average_trend.sv */
// Two-axis (Y, Z) boxcar moving average with trend and latched baseline. One
// transaction is taken per clock cycle whenever the output is free or being
// taken. An accepted transaction passes four register stages before m_tvalid
// rises for its result: the running-sum update, the reciprocal multiply, the
// quotient correction and the baseline merge. Both axes run in their own lane
// side by side. The sample history holds WINDOW samples per axis and starts
// at zero after reset. The baseline latches on the WINDOW-th transaction after
// reset, and calibrated is high from that result on. While m_tready is low
// with a result pending, the whole pipeline holds and s_tready drops.
`default_nettype none

module dual_axis_window_average_trend #(
	parameter int WINDOW      = 50,
	parameter int RECENT      = 40,
	parameter int SAMPLE_BITS = 10
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             s_tvalid,
	output logic                                  s_tready,
	// y_sample[9:0], z_sample[19:10], zero pad
	input  wire logic [wad_pkg::S_TDATA_W-1:0]    s_tdata,
	output logic                                  m_tvalid,
	input  wire logic                             m_tready,
	// y_level[10:0], z_level[21:11], y_trend[32:22], z_trend[43:33], zero pad
	output logic [wad_pkg::M_TDATA_W-1:0]         m_tdata,
	// calibrated[0]
	output logic [wad_pkg::M_TUSER_W-1:0]         m_tuser
);

	import wad_pkg::*;

	logic             en;
	logic             accept;
	logic             valid_s1;
	logic             valid_s2;
	logic             valid_s3;
	lane_mean_t       y_mean;
	lane_mean_t       z_mean;
	logic [OUT_W-1:0] y_level;
	logic [OUT_W-1:0] z_level;
	logic [OUT_W-1:0] y_trend;
	logic [OUT_W-1:0] z_trend;
	logic             calibrated;

	assign en       = !m_tvalid || m_tready;
	assign s_tready = en;
	assign accept   = s_tvalid && en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else if (en) begin
			valid_s1 <= accept;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	wad_lane #(.WINDOW(WINDOW), .RECENT(RECENT), .SAMPLE_BITS(SAMPLE_BITS)) u_y_lane (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.accept (accept),
		.sample (s_tdata[IN_W-1:0]),
		.mean   (y_mean)
	);

	wad_lane #(.WINDOW(WINDOW), .RECENT(RECENT), .SAMPLE_BITS(SAMPLE_BITS)) u_z_lane (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.accept (accept),
		.sample (s_tdata[2*IN_W-1:IN_W]),
		.mean   (z_mean)
	);

	wad_merge #(.WINDOW(WINDOW)) u_merge (
		.clk        (clk),
		.arst_n     (arst_n),
		.en         (en),
		.in_valid   (valid_s3),
		.y_mean     (y_mean),
		.z_mean     (z_mean),
		.out_valid  (m_tvalid),
		.y_level    (y_level),
		.z_level    (z_level),
		.y_trend    (y_trend),
		.z_trend    (z_trend),
		.calibrated (calibrated)
	);

	assign m_tdata = M_TDATA_W'({z_trend, y_trend, z_level, y_level});
	assign m_tuser = M_TUSER_W'(calibrated);

endmodule

`default_nettype wire

/* rtl/core/wad_cdiv.sv */
// two-stage divider by a constant: reciprocal multiply, then one correction step
`default_nettype none

module wad_cdiv #(
	parameter int DIV   = 50,
	parameter int WIDTH = 16
) (
	input  wire logic             clk,
	input  wire logic             en,
	input  wire logic [WIDTH-1:0] x,
	output logic      [WIDTH-1:0] q
);

	localparam int PW = 2 * WIDTH + 1;
	localparam int unsigned RECIP_I = (2 ** WIDTH) / DIV;
	localparam logic [WIDTH:0] RECIP = (WIDTH + 1)'(RECIP_I);
	localparam logic [WIDTH-1:0] DIV_W = WIDTH'(DIV);

	logic [PW-1:0]    prod_s2;
	logic [WIDTH-1:0] x_s2;
	logic [WIDTH-1:0] q_est;
	logic [WIDTH-1:0] rem;
	logic [WIDTH-1:0] q_s3;

	// estimate is exact or one low
	assign q_est = prod_s2[2*WIDTH-1:WIDTH];
	assign rem   = x_s2 - WIDTH'(q_est * DIV_W);

	always_ff @(posedge clk) begin
		if (en) begin
			prod_s2 <= PW'(x) * PW'(RECIP);
			x_s2    <= x;
			q_s3    <= (rem >= DIV_W) ? q_est + WIDTH'(1) : q_est;
		end
	end

	assign q = q_s3;

endmodule

`default_nettype wire

/* rtl/core/wad_lane.sv */
// one axis lane: sample history shift line, running sums and the two mean dividers
`default_nettype none

module wad_lane #(
	parameter int WINDOW      = 50,
	parameter int RECENT      = 40,
	parameter int SAMPLE_BITS = 10
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      en,
	input  wire logic                      accept,
	input  wire logic [wad_pkg::IN_W-1:0]  sample,
	output wad_pkg::lane_mean_t            mean
);

	import wad_pkg::*;

	localparam int SW   = (SAMPLE_BITS < IN_W) ? SAMPLE_BITS : IN_W;
	localparam int REFF = (RECENT < WINDOW) ? RECENT : WINDOW;
	localparam int SUMW = SW + $clog2(WINDOW);

	logic [SW-1:0]   hist_q [WINDOW];
	logic [SUMW-1:0] full_q;
	logic [SUMW-1:0] recent_q;
	logic [SUMW-1:0] full_next;
	logic [SUMW-1:0] recent_next;
	logic [SUMW-1:0] full_s1;
	logic [SUMW-1:0] recent_s1;
	logic [SUMW-1:0] full_mean;
	logic [SUMW-1:0] recent_mean;
	logic [SW-1:0]   new_smp;

	// bits above the sample width are dropped
	assign new_smp = sample[SW-1:0];

	always_comb begin
		full_next = full_q + SUMW'(new_smp) - SUMW'(hist_q[WINDOW-1]);
		if (REFF == WINDOW) begin
			recent_next = full_next;
		end else begin
			recent_next = recent_q + SUMW'(new_smp) - SUMW'(hist_q[REFF-1]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < WINDOW; i++) begin
				hist_q[i] <= '0;
			end
			full_q   <= '0;
			recent_q <= '0;
		end else if (accept) begin
			hist_q[0] <= new_smp;
			for (int i = 1; i < WINDOW; i++) begin
				hist_q[i] <= hist_q[i-1];
			end
			full_q   <= full_next;
			recent_q <= recent_next;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			full_s1   <= full_next;
			recent_s1 <= recent_next;
		end
	end

	wad_cdiv #(.DIV(WINDOW), .WIDTH(SUMW)) u_full_div (
		.clk (clk),
		.en  (en),
		.x   (full_s1),
		.q   (full_mean)
	);

	wad_cdiv #(.DIV(REFF), .WIDTH(SUMW)) u_recent_div (
		.clk (clk),
		.en  (en),
		.x   (recent_s1),
		.q   (recent_mean)
	);

	assign mean.full   = IN_W'(full_mean[SW-1:0]);
	assign mean.recent = IN_W'(recent_mean[SW-1:0]);

endmodule

`default_nettype wire

/* rtl/core/wad_merge.sv */
// merging stage: warmup count, baseline latch, level and trend, output register
`default_nettype none

module wad_merge #(
	parameter int WINDOW = 50
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      en,
	input  wire logic                      in_valid,
	input  wire wad_pkg::lane_mean_t       y_mean,
	input  wire wad_pkg::lane_mean_t       z_mean,
	output logic                           out_valid,
	output logic [wad_pkg::OUT_W-1:0]      y_level,
	output logic [wad_pkg::OUT_W-1:0]      z_level,
	output logic [wad_pkg::OUT_W-1:0]      y_trend,
	output logic [wad_pkg::OUT_W-1:0]      z_trend,
	output logic                           calibrated
);

	import wad_pkg::*;

	localparam int CNT_W = $clog2(WINDOW + 1);
	localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(WINDOW);

	logic [CNT_W-1:0] cnt_q;
	logic [CNT_W-1:0] cnt_next;
	logic             done_q;
	logic             latch;
	logic [IN_W-1:0]  y_base_q;
	logic [IN_W-1:0]  z_base_q;
	logic [IN_W-1:0]  y_base;
	logic [IN_W-1:0]  z_base;
	logic             valid_s4;
	logic [OUT_W-1:0] y_level_s4;
	logic [OUT_W-1:0] z_level_s4;
	logic [OUT_W-1:0] y_trend_s4;
	logic [OUT_W-1:0] z_trend_s4;
	logic             cal_s4;

	assign cnt_next = (cnt_q < CNT_MAX) ? cnt_q + CNT_W'(1) : cnt_q;
	assign latch    = !done_q && (cnt_next == CNT_MAX);
	// the latching transaction already sees its own baseline
	assign y_base   = latch ? y_mean.full : y_base_q;
	assign z_base   = latch ? z_mean.full : z_base_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q    <= '0;
			done_q   <= 1'b0;
			y_base_q <= '0;
			z_base_q <= '0;
			valid_s4 <= 1'b0;
		end else if (en) begin
			valid_s4 <= in_valid;
			if (in_valid) begin
				cnt_q <= cnt_next;
				if (latch) begin
					done_q   <= 1'b1;
					y_base_q <= y_mean.full;
					z_base_q <= z_mean.full;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en && in_valid) begin
			y_level_s4 <= OUT_W'(y_mean.full) - OUT_W'(y_base);
			z_level_s4 <= OUT_W'(z_mean.full) - OUT_W'(z_base);
			y_trend_s4 <= OUT_W'(y_mean.full) - OUT_W'(y_mean.recent);
			z_trend_s4 <= OUT_W'(z_mean.full) - OUT_W'(z_mean.recent);
			cal_s4     <= done_q || latch;
		end
	end

	assign out_valid  = valid_s4;
	assign y_level    = y_level_s4;
	assign z_level    = z_level_s4;
	assign y_trend    = y_trend_s4;
	assign z_trend    = z_trend_s4;
	assign calibrated = cal_s4;

endmodule

`default_nettype wire
